// ===== rtl/imp2_pkg.sv =====
package imp2_pkg;

    // Fixed field widths of the two channels.
    localparam int OPERAND_W = 64;
    localparam int COUNT_W   = 7;

    typedef struct packed {
        logic [OPERAND_W-1:0] operand;
        logic [COUNT_W-1:0]   bit_count;
    } t_in_word;

    typedef struct packed {
        logic [OPERAND_W-1:0] inverse;
        logic                 bad_input;
    } t_out_word;

    // Microprogram addressing.
    localparam int PC_W = 3;
    typedef logic [PC_W-1:0] t_pc;

    localparam t_pc PC_CHECK = 3'd0;
    localparam t_pc PC_OUT   = 3'd7;

    // Multiplier operand pair: c * inv or inv * t.
    typedef enum logic {
        SRC_C_INV,
        SRC_INV_T
    } t_src;

    // Which half-width partial product the shared multiplier forms.
    typedef enum logic [1:0] {
        PART_NONE,
        PART_LL,
        PART_LH,
        PART_HL
    } t_part;

    // Where the accumulated product goes.
    typedef enum logic [1:0] {
        DST_ACC,
        DST_T,
        DST_INV
    } t_dest;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_IF_DONE,
        JMP_GOTO,
        JMP_OUT
    } t_jump;

    typedef struct packed {
        t_src  src;
        t_part part;
        t_dest dest;
        t_jump jump;
        t_pc   target;
    } t_uinstr;

    // Datapath control from the sequencer.
    typedef struct packed {
        logic    load;
        logic    step;
        t_uinstr uinstr;
    } t_dp_ctl;

    // One Newton step is two low-half products, each built from three
    // partial products. The step that finishes inv also doubles the
    // count of correct bits and loops back to the check.
    function automatic t_uinstr ucode(input t_pc pc);
        t_uinstr w;
        unique case (pc)
            3'd0:    w = '{SRC_C_INV, PART_NONE, DST_ACC, JMP_IF_DONE, PC_OUT};
            3'd1:    w = '{SRC_C_INV, PART_LL,   DST_ACC, JMP_NEXT,    PC_CHECK};
            3'd2:    w = '{SRC_C_INV, PART_LH,   DST_ACC, JMP_NEXT,    PC_CHECK};
            3'd3:    w = '{SRC_C_INV, PART_HL,   DST_T,   JMP_NEXT,    PC_CHECK};
            3'd4:    w = '{SRC_INV_T, PART_LL,   DST_ACC, JMP_NEXT,    PC_CHECK};
            3'd5:    w = '{SRC_INV_T, PART_LH,   DST_ACC, JMP_NEXT,    PC_CHECK};
            3'd6:    w = '{SRC_INV_T, PART_HL,   DST_INV, JMP_GOTO,    PC_CHECK};
            default: w = '{SRC_C_INV, PART_NONE, DST_ACC, JMP_OUT,     PC_CHECK};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/imp2_datapath.sv =====
module imp2_datapath #(
    parameter int WIDTH = 64
) (
    input  logic                       i_clk,
    input  imp2_pkg::t_dp_ctl          i_ctl,
    input  logic [WIDTH-1:0]           i_operand,
    input  logic [imp2_pkg::COUNT_W-1:0] i_bit_count,
    output logic                       o_done,
    output logic [WIDTH-1:0]           o_result
);
    import imp2_pkg::*;

    localparam int H  = (WIDTH + 1) / 2;
    localparam int KW = $clog2(WIDTH + 1);
    localparam int GW = KW + 1;
    localparam logic [WIDTH-1:0] TWO = WIDTH'(2);

    logic [WIDTH-1:0] r_c, r_inv, r_t, r_acc, r_km;
    logic [KW-1:0]    r_k;
    logic [GW-1:0]    r_good;

    logic [KW-1:0]    k_sat;
    logic [WIDTH-1:0] km;
    logic [WIDTH-1:0] a_sel, b_sel;
    logic [2*H-1:0]   ap, bp;
    logic [H-1:0]     ma, mb;
    logic [2*H-1:0]   pp;
    logic [WIDTH-1:0] sum;

    always_comb begin
        // Bit counts above WIDTH saturate.
        if (i_bit_count > COUNT_W'(WIDTH)) begin
            k_sat = KW'(WIDTH);
        end else begin
            k_sat = KW'(i_bit_count);
        end
        km = ~({WIDTH{1'b1}} << k_sat);

        a_sel = (i_ctl.uinstr.src == SRC_C_INV) ? r_c : r_inv;
        b_sel = (i_ctl.uinstr.src == SRC_C_INV) ? r_inv : r_t;
        ap = (2*H)'(a_sel);
        bp = (2*H)'(b_sel);

        case (i_ctl.uinstr.part)
            PART_LH: begin
                ma = ap[H-1:0];
                mb = bp[2*H-1:H];
            end
            PART_HL: begin
                ma = ap[2*H-1:H];
                mb = bp[H-1:0];
            end
            default: begin
                ma = ap[H-1:0];
                mb = bp[H-1:0];
            end
        endcase
        pp = ma * mb;

        // Only the low word of the full product is kept, so the cross
        // terms contribute just their low halves shifted up.
        if (i_ctl.uinstr.part == PART_LL) begin
            sum = WIDTH'(pp);
        end else begin
            sum = r_acc + WIDTH'({pp, {H{1'b0}}});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_c    <= i_operand & km;
            r_inv  <= i_operand & km;
            r_km   <= km;
            r_k    <= k_sat;
            r_good <= GW'(3);
        end else if (i_ctl.step && i_ctl.uinstr.part != PART_NONE) begin
            case (i_ctl.uinstr.dest)
                DST_T: begin
                    r_t <= TWO - sum;
                end
                DST_INV: begin
                    r_inv  <= sum;
                    r_good <= r_good << 1;
                end
                default: begin
                    r_acc <= sum;
                end
            endcase
        end
    end

    assign o_done   = (r_good >= GW'(r_k));
    assign o_result = r_inv & r_km;

endmodule

// ===== rtl/inverse_mod_power_of_two.sv =====
// An accepted word is lifted n times before its result is valid, where n is
// the number of lifting steps (0 for k up to 3, 5 for k above 48); an even operand
// or a zero bit count goes straight to the output step.
// One word is in work at a time, paced by the single half-width multiplier that
// forms three partial products per product, two products per lifting step; a new
// word is accepted only once the previous one has taken the output step, which
// waits while the result before it is still unclaimed.
// Reset is synchronous, active low, and clears the sequencer and output valid.
module inverse_mod_power_of_two #(
    parameter int WIDTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  imp2_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output imp2_pkg::t_out_word o_out_word
);
    import imp2_pkg::*;

    logic      r_busy, r_bad, r_out_valid;
    t_pc       r_pc;
    t_out_word r_out_word;

    t_uinstr   uinstr;
    t_dp_ctl   dp_ctl;
    logic      accept, step_en, out_fire, dp_done;
    logic      in_bad;
    logic [WIDTH-1:0] dp_result;

    assign accept  = i_in_valid && o_in_ready;
    assign in_bad  = (i_in_word.bit_count == '0) || !i_in_word.operand[0];
    assign uinstr  = ucode(r_pc);
    // The output step waits while the previous word is still unclaimed.
    assign step_en = r_busy &&
                     !(uinstr.jump == JMP_OUT && r_out_valid && !i_out_ready);
    assign out_fire = step_en && uinstr.jump == JMP_OUT;

    assign dp_ctl.load   = accept;
    assign dp_ctl.step   = step_en;
    assign dp_ctl.uinstr = uinstr;

    imp2_datapath #(
        .WIDTH(WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_ctl       (dp_ctl),
        .i_operand   (i_in_word.operand[WIDTH-1:0]),
        .i_bit_count (i_in_word.bit_count),
        .o_done      (dp_done),
        .o_result    (dp_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= PC_CHECK;
            r_out_valid <= 1'b0;
            r_bad       <= 1'b0;
        end else begin
            // A new word replaces the one being claimed in the same cycle.
            if (out_fire) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                r_busy <= 1'b1;
                r_bad  <= in_bad;
                r_pc   <= in_bad ? PC_OUT : PC_CHECK;
            end else if (step_en) begin
                unique case (uinstr.jump)
                    JMP_NEXT: begin
                        r_pc <= r_pc + t_pc'(1);
                    end
                    JMP_IF_DONE: begin
                        r_pc <= dp_done ? uinstr.target : r_pc + t_pc'(1);
                    end
                    JMP_GOTO: begin
                        r_pc <= uinstr.target;
                    end
                    JMP_OUT: begin
                        r_busy <= 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire) begin
            r_out_word.bad_input <= r_bad;
            r_out_word.inverse   <= r_bad ? '0 : OPERAND_W'(dp_result);
        end
    end

    assign o_in_ready  = !r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.bad_input |-> o_out_word.inverse == '0)
        else $error("bad input word carries a nonzero inverse");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_busy && (r_pc == PC_CHECK || r_pc == PC_OUT))
        else $error("accepted word did not start the microprogram");

    a_out_on_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire |=> r_out_valid && !r_busy)
        else $error("output step did not present a word");

endmodule

// ===== sim/inverse_mod_power_of_two_tb.sv =====
module inverse_mod_power_of_two_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import imp2_pkg::*;

    localparam int WIDTH         = 64;
    localparam int RANDOM_WORDS  = 675;
    localparam int CALM_WORDS    = 100;
    localparam int STALL_LIMIT   = 1000;
    localparam int DRAIN_CYCLES  = 60;
    localparam int SHOWN_ERRORS  = 10;
    localparam logic [63:0] ONES = '1;

    // One row of the directed table. Rows with typed set carry their own answer.
    typedef struct packed {
        logic [63:0] operand;
        logic [6:0]  bit_count;
        logic        typed;
        logic [63:0] inverse;
        logic        bad_input;
    } t_case;

    localparam int NUM_CASES = 25;
    localparam t_case DIRECTED [NUM_CASES] = '{
        '{64'h2,                   7'd5,   1'b1, 64'h0,  1'b1},
        '{64'h0,                   7'd64,  1'b1, 64'h0,  1'b1},
        '{64'h1,                   7'd0,   1'b1, 64'h0,  1'b1},
        '{ONES,                    7'd0,   1'b1, 64'h0,  1'b1},
        '{64'hFFFF_FFFF_FFFF_FFFE, 7'd64,  1'b1, 64'h0,  1'b1},
        '{64'h1,                   7'd64,  1'b1, 64'h1,  1'b0},
        '{ONES,                    7'd64,  1'b1, ONES,   1'b0},
        '{ONES,                    7'd127, 1'b1, ONES,   1'b0},
        '{64'h1,                   7'd65,  1'b1, 64'h1,  1'b0},
        '{64'h3,                   7'd1,   1'b1, 64'h1,  1'b0},
        '{ONES,                    7'd1,   1'b1, 64'h1,  1'b0},
        '{64'h8000_0000_0000_0001, 7'd63,  1'b1, 64'h1,  1'b0},
        '{64'h3,                   7'd2,   1'b0, 64'h0,  1'b0},
        '{64'h5,                   7'd3,   1'b0, 64'h0,  1'b0},
        '{64'h7,                   7'd4,   1'b0, 64'h0,  1'b0},
        '{64'h0123_4567_89AB_CDEF, 7'd6,   1'b0, 64'h0,  1'b0},
        '{64'hA5A5_5A5A_C3C3_3C3D, 7'd7,   1'b0, 64'h0,  1'b0},
        '{64'h0123_4567_89AB_CDEF, 7'd12,  1'b0, 64'h0,  1'b0},
        '{64'hA5A5_5A5A_C3C3_3C3D, 7'd13,  1'b0, 64'h0,  1'b0},
        '{64'hDEAD_BEEF_CAFE_F00D, 7'd24,  1'b0, 64'h0,  1'b0},
        '{64'h7FFF_FFFF_FFFF_FFFF, 7'd25,  1'b0, 64'h0,  1'b0},
        '{64'hDEAD_BEEF_CAFE_F00D, 7'd48,  1'b0, 64'h0,  1'b0},
        '{64'h5555_5555_5555_5555, 7'd49,  1'b0, 64'h0,  1'b0},
        '{64'hAAAA_AAAA_AAAA_AAAB, 7'd63,  1'b0, 64'h0,  1'b0},
        '{64'h0123_4567_89AB_CDEF, 7'd100, 1'b0, 64'h0,  1'b0}
    };

    // Bit counts on each side of a change in lifting steps, and near the ends.
    localparam int STEP_BOUNDS [14] = '{1, 2, 3, 4, 6, 7, 12, 13, 24, 25, 48, 49, 63, 64};

    typedef struct {
        t_in_word  word;
        t_out_word want;
    } t_pending;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_ready;
    t_out_word out_word;

    t_pending  inverses_due [$];
    int        mismatches   = 0;
    int        results_seen = 0;
    int        quiet_cycles = 0;
    bit        calm         = 1'b0;
    int        gap_odds     = 0;

    inverse_mod_power_of_two #(
        .WIDTH(WIDTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_word (out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Newton step inv <- inv * (2 - c * inv), starting from c, until the
    // count of correct bits reaches k.
    function automatic t_out_word hensel_inverse(input t_in_word w);
        t_out_word   res;
        logic [63:0] wmask;
        logic [63:0] kmask;
        logic [63:0] c;
        logic [63:0] inv;
        logic [63:0] t;
        int unsigned k;
        int unsigned good;
        wmask = (WIDTH >= 64) ? ONES : ((64'd1 << WIDTH) - 64'd1);
        k = w.bit_count;
        if (k > WIDTH) begin
            k = WIDTH;
        end
        if (k == 0 || !w.operand[0]) begin
            res.inverse   = '0;
            res.bad_input = 1'b1;
            return res;
        end
        kmask = (k >= 64) ? ONES : ((64'd1 << k) - 64'd1);
        c   = w.operand & kmask;
        inv = c;
        for (good = 3; good < k; good = good * 2) begin
            t   = (c * inv) & wmask;
            t   = (64'd2 - t) & wmask;
            inv = (inv * t) & wmask;
        end
        res.inverse   = inv & kmask;
        res.bad_input = 1'b0;
        return res;
    endfunction

    function automatic t_in_word random_word();
        t_in_word    w;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            w.operand = ONES;
        end else if (pick < 14) begin
            w.operand = 64'd1 << $urandom_range(0, 63);
        end else begin
            w.operand = {$urandom, $urandom};
        end
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            w.bit_count = 7'd0;
        end else if (pick < 12) begin
            w.bit_count = 7'($urandom_range(65, 127));
        end else if (pick < 26) begin
            w.bit_count = 7'(STEP_BOUNDS[$urandom_range(0, 13)]);
        end else begin
            w.bit_count = 7'($urandom_range(1, 64));
        end
        // Most operands are odd so that the lifting loop gets exercised.
        w.operand[0] = ($urandom_range(0, 9) != 0);
        return w;
    endfunction

    task automatic offer_word(input t_in_word w, input t_out_word want);
        t_pending entry;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 15) < gap_odds) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (!in_ready);
        entry.word = w;
        entry.want = want;
        inverses_due.push_back(entry);
    endtask

    task automatic report_mismatch(input t_in_word w, input t_out_word want,
                                   input t_out_word got);
        mismatches++;
        if (mismatches <= SHOWN_ERRORS) begin
            $display("result %0d operand %h count %0d: expected inverse %h bad %b, got inverse %h bad %b",
                     results_seen, w.operand, w.bit_count, want.inverse, want.bad_input,
                     got.inverse, got.bad_input);
        end
    endtask

    // Result stall bursts; the stall rate is redrawn now and then so that
    // there are stretches with no stalls at all.
    initial begin
        int hold;
        int cycle;
        int stall_odds;
        hold       = 0;
        cycle      = 0;
        stall_odds = 0;
        out_ready  = 1'b0;
        forever begin
            @(negedge i_clk);
            cycle++;
            if (cycle % 40 == 0) begin
                stall_odds = $urandom_range(0, 2) * 4;
            end
            if (hold > 0) begin
                hold--;
                out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 15) < stall_odds) begin
                hold = $urandom_range(0, 5);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_pending head;
        if (i_rst_n && out_valid && out_ready) begin
            if (inverses_due.size() == 0) begin
                report_mismatch('0, '0, out_word);
            end else begin
                head = inverses_due.pop_front();
                if (out_word.inverse !== head.want.inverse
                        || out_word.bad_input !== head.want.bad_input) begin
                    report_mismatch(head.word, head.want, out_word);
                end
            end
            results_seen++;
        end
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("inverse_mod_power_of_two: mismatch");
                $finish;
            end
        end
    end

    initial begin
        t_in_word  w;
        t_out_word want;
        i_rst_n  = 1'b0;
        in_valid = 1'b0;
        in_word  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) begin
            w.operand   = DIRECTED[i].operand;
            w.bit_count = DIRECTED[i].bit_count;
            if (DIRECTED[i].typed) begin
                want.inverse   = DIRECTED[i].inverse;
                want.bad_input = DIRECTED[i].bad_input;
            end else begin
                want = hensel_inverse(w);
            end
            offer_word(w, want);
        end

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 30 == 0) begin
                gap_odds = $urandom_range(0, 2) * 4;
            end
            calm = (n >= RANDOM_WORDS - CALM_WORDS);
            w = random_word();
            offer_word(w, hensel_inverse(w));
        end
        @(negedge i_clk);
        in_valid <= 1'b0;

        wait (inverses_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && inverses_due.size() == 0) begin
            $display("inverse_mod_power_of_two: match");
        end else begin
            $display("inverse_mod_power_of_two: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/imp2_pkg.sv
rtl/imp2_datapath.sv
rtl/inverse_mod_power_of_two.sv
sim/inverse_mod_power_of_two_tb.sv
